[rtl/binary_arithmetic_bin_decoder_macros.svh]
// assertion macros used by the decoder datapath bad_dp
// expects clk and arst_n in the scope of use
`ifndef BINARY_ARITHMETIC_BIN_DECODER_MACROS_SVH
`define BINARY_ARITHMETIC_BIN_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define BAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/bad_pkg.sv]
// types, constants and helper functions of the binary arithmetic bin decoder
// used by bad_ctl, bad_dp and the top level; no dependencies
`timescale 1ns / 1ps

package bad_pkg;

	localparam int NUM_CONTEXTS_DEF = 256;
	localparam int BUFFER_BITS_DEF  = 64;

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_START = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_REG   = 3'd3,
		CMD_WGT   = 3'd4,
		CMD_BYP   = 3'd5,
		CMD_STF   = 3'd6,
		CMD_NOP   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MORE = 2'd1,
		ST_OVER = 2'd2,
		ST_IDLE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_SHIFT9, S_NORM_S, S_RD1, S_RD2, S_SPLIT,
		S_RENORM, S_VNORM, S_COMMIT, S_ADAPT1, S_ADAPT2, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_PUSH, OP_START_INIT, OP_CLEAR, OP_LOAD,
		OP_LAT1, OP_LAT2, OP_SPLIT, OP_SHIFT_START, OP_SHIFT_NORM,
		OP_RENORM_STEP, OP_RENORM_END, OP_COMMIT, OP_COMMIT_START,
		OP_ADAPT1, OP_ADAPT2, OP_SET_STATUS
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
		logic    out_load;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic started;
		logic have_bit;
		logic vt_low;
		logic i9;
		logic lr_low;
		logic split_mps;
		logic split_same;
		logic full;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [1:0] cycle;
		logic       mps;
		logic [9:0] prob;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{cycle: 2'd0, mps: 1'b0, prob: 10'd1023};

	// index reduction by restoring subtraction, eight steps
	function automatic logic [7:0] ctx_mod(input logic [7:0] idx, input logic [10:0] n);
		logic [18:0] r;
		logic [18:0] s;
		r = {11'd0, idx};
		for (int k = 7; k >= 0; k--) begin
			s = {8'd0, n} << k;
			if (r >= s) begin
				r = r - s;
			end
		end
		return r[7:0];
	endfunction

	function automatic ctx_t ctx_adapt(input ctx_t c, input logic bin);
		ctx_t        r;
		logic [10:0] p;
		logic [2:0]  cwr;
		logic [10:0] d;
		r   = c;
		p   = {1'b0, c.prob};
		cwr = (c.cycle <= 2'd1) ? 3'd3 : ((c.cycle == 2'd2) ? 3'd4 : 3'd5);
		if (bin != c.mps) begin
			if (c.cycle <= 2'd2) begin
				r.cycle = c.cycle + 2'd1;
			end
			d = (cwr == 3'd3) ? 11'd197 : ((cwr == 3'd4) ? 11'd95 : 11'd46);
			p = p + d;
			if (p > 11'd1023) begin
				p     = 11'd2047 - p;
				r.mps = ~c.mps;
			end
		end else begin
			if (c.cycle == 2'd0) begin
				r.cycle = 2'd1;
			end
			p = p - (p >> cwr) - (p >> (cwr + 3'd2));
		end
		r.prob = p[9:0];
		return r;
	endfunction

endpackage

[rtl/bad_ctl.sv]
// command sequencer of the bin decoder
// depends on bad_pkg; drives bad_dp through ctl_t, reads dp_stat_t
`timescale 1ns / 1ps

module bad_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bad_pkg::dp_stat_t st,
	output bad_pkg::ctl_t     ctl
);

	bad_pkg::state_t state_q, state_d;
	logic two_ctx;
	logic uses_ctx;

	assign two_ctx  = (st.cmd == bad_pkg::CMD_WGT);
	assign uses_ctx = (st.cmd == bad_pkg::CMD_REG) || two_ctx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.op       = bad_pkg::OP_NONE;
		ctl.status   = bad_pkg::ST_OK;
		ctl.out_load = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			bad_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = bad_pkg::OP_CAPTURE;
					state_d = bad_pkg::S_DISPATCH;
				end
			end
			bad_pkg::S_DISPATCH: begin
				state_d = bad_pkg::S_DONE;
				unique case (st.cmd)
					bad_pkg::CMD_PUSH: begin
						if (st.full) begin
							ctl.op     = bad_pkg::OP_SET_STATUS;
							ctl.status = bad_pkg::ST_OVER;
						end else begin
							ctl.op = bad_pkg::OP_PUSH;
						end
					end
					bad_pkg::CMD_START: begin
						ctl.op  = bad_pkg::OP_START_INIT;
						state_d = bad_pkg::S_SHIFT9;
					end
					bad_pkg::CMD_CLEAR: ctl.op = bad_pkg::OP_CLEAR;
					bad_pkg::CMD_REG, bad_pkg::CMD_WGT,
					bad_pkg::CMD_BYP, bad_pkg::CMD_STF: begin
						if (!st.started) begin
							ctl.op     = bad_pkg::OP_SET_STATUS;
							ctl.status = bad_pkg::ST_IDLE;
						end else begin
							ctl.op  = bad_pkg::OP_LOAD;
							state_d = uses_ctx ? bad_pkg::S_RD1 : bad_pkg::S_SPLIT;
						end
					end
					default: ctl.op = bad_pkg::OP_NONE;
				endcase
			end
			bad_pkg::S_SHIFT9: begin
				if (st.i9) begin
					state_d = bad_pkg::S_NORM_S;
				end else if (!st.have_bit) begin
					ctl.op     = bad_pkg::OP_SET_STATUS;
					ctl.status = bad_pkg::ST_MORE;
					state_d    = bad_pkg::S_DONE;
				end else begin
					ctl.op = bad_pkg::OP_SHIFT_START;
				end
			end
			bad_pkg::S_NORM_S: begin
				if (!st.vt_low) begin
					ctl.op  = bad_pkg::OP_COMMIT_START;
					state_d = bad_pkg::S_DONE;
				end else if (!st.have_bit) begin
					ctl.op     = bad_pkg::OP_SET_STATUS;
					ctl.status = bad_pkg::ST_MORE;
					state_d    = bad_pkg::S_DONE;
				end else begin
					ctl.op = bad_pkg::OP_SHIFT_NORM;
				end
			end
			bad_pkg::S_RD1: begin
				ctl.op  = bad_pkg::OP_LAT1;
				state_d = two_ctx ? bad_pkg::S_RD2 : bad_pkg::S_SPLIT;
			end
			bad_pkg::S_RD2: begin
				ctl.op  = bad_pkg::OP_LAT2;
				state_d = bad_pkg::S_SPLIT;
			end
			bad_pkg::S_SPLIT: begin
				if (st.split_mps) begin
					ctl.op  = bad_pkg::OP_SPLIT;
					state_d = bad_pkg::S_COMMIT;
				end else if (st.split_same || st.have_bit) begin
					ctl.op  = bad_pkg::OP_SPLIT;
					state_d = bad_pkg::S_RENORM;
				end else begin
					ctl.op     = bad_pkg::OP_SET_STATUS;
					ctl.status = bad_pkg::ST_MORE;
					state_d    = bad_pkg::S_DONE;
				end
			end
			bad_pkg::S_RENORM: begin
				if (st.lr_low && !st.i9) begin
					if (st.have_bit) begin
						ctl.op = bad_pkg::OP_RENORM_STEP;
					end else begin
						ctl.op     = bad_pkg::OP_SET_STATUS;
						ctl.status = bad_pkg::ST_MORE;
						state_d    = bad_pkg::S_DONE;
					end
				end else begin
					ctl.op  = bad_pkg::OP_RENORM_END;
					state_d = bad_pkg::S_VNORM;
				end
			end
			bad_pkg::S_VNORM: begin
				if (st.vt_low) begin
					if (st.have_bit) begin
						ctl.op = bad_pkg::OP_SHIFT_NORM;
					end else begin
						ctl.op     = bad_pkg::OP_SET_STATUS;
						ctl.status = bad_pkg::ST_MORE;
						state_d    = bad_pkg::S_DONE;
					end
				end else begin
					ctl.op  = bad_pkg::OP_COMMIT;
					state_d = uses_ctx ? bad_pkg::S_ADAPT1 : bad_pkg::S_DONE;
				end
			end
			bad_pkg::S_COMMIT: begin
				ctl.op  = bad_pkg::OP_COMMIT;
				state_d = uses_ctx ? bad_pkg::S_ADAPT1 : bad_pkg::S_DONE;
			end
			bad_pkg::S_ADAPT1: begin
				ctl.op  = bad_pkg::OP_ADAPT1;
				state_d = two_ctx ? bad_pkg::S_ADAPT2 : bad_pkg::S_DONE;
			end
			bad_pkg::S_ADAPT2: begin
				ctl.op  = bad_pkg::OP_ADAPT2;
				state_d = bad_pkg::S_DONE;
			end
			bad_pkg::S_DONE: begin
				if (st.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = bad_pkg::S_IDLE;
				end
			end
			default: state_d = bad_pkg::S_IDLE;
		endcase
	end

endmodule

[rtl/bad_dp.sv]
// datapath of the bin decoder: bit buffer, interval registers, context memory
// depends on bad_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "binary_arithmetic_bin_decoder_macros.svh"

module bad_dp #(
	parameter int NUM_CONTEXTS = bad_pkg::NUM_CONTEXTS_DEF,
	parameter int BUFFER_BITS  = bad_pkg::BUFFER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       in_data,
	input  bad_pkg::ctl_t     ctl,
	output bad_pkg::dp_stat_t st,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [47:0]       out_data
);

	localparam int CNT_W  = $clog2(BUFFER_BITS + 1);
	localparam int IDX_W  = $clog2(BUFFER_BITS);
	localparam int CIDX_W = $clog2(NUM_CONTEXTS);

	// captured command
	bad_pkg::cmd_t     cmd_q;
	logic [7:0]        byte_q;
	logic [CIDX_W-1:0] idx1_q, idx2_q;

	// architectural state
	logic [BUFFER_BITS-1:0] buf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [7:0]             rs_q, rt_q, vs_q;
	logic [8:0]             vf_q;
	logic [31:0]            cons_q;
	logic                   started_q;

	// working copy
	logic [7:0]       w_rs_q, w_rt_q, w_vs_q;
	logic [15:0]      w_vt_q;
	logic [CNT_W-1:0] taken_q;
	logic [3:0]       i_q;
	logic [9:0]       lr_q;
	logic             bin_q;
	bad_pkg::status_t stat_q;
	bad_pkg::ctx_t    c1_q, c2_q;

	// context memory
	bad_pkg::ctx_t     mem [NUM_CONTEXTS];
	logic [NUM_CONTEXTS-1:0] vld_q;
	bad_pkg::ctx_t     rd_q;
	logic              rvld_q;
	bad_pkg::ctx_t     rd_entry;
	logic [CIDX_W-1:0] rd_addr;
	logic              mem_we;
	logic [CIDX_W-1:0] wr_addr;
	bad_pkg::ctx_t     wr_data;
	bad_pkg::ctx_t     adapt1;

	// output register
	logic        out_valid_q;
	logic [47:0] out_data_q;

	// combinational helpers
	logic [IDX_W-1:0]       bit_idx;
	logic                   cur_bit;
	logic [15:0]            vt_shift;
	logic [CNT_W:0]         cnt_ext;
	logic [CNT_W-1:0]       push_sh;
	logic [BUFFER_BITS-1:0] push_vec;
	logic                   pred;
	logic [9:0]             lg;
	logic [10:0]            psum;
	logic [9:0]             pdiff;
	logic [7:0]             x;
	logic                   wrap;
	logic [8:0]             rs_inc;
	logic [7:0]             rs2;
	logic [8:0]             rt2;
	logic                   mps_path;
	logic [16:0]            vt_sub;
	logic [7:0]             vs_sat;
	logic [7:0]             mi1, mi2;

	assign bit_idx  = IDX_W'(BUFFER_BITS - 1) - taken_q[IDX_W-1:0];
	assign cur_bit  = buf_q[bit_idx];
	assign vt_shift = {w_vt_q[14:0], cur_bit};
	assign cnt_ext  = {1'b0, cnt_q} + (CNT_W + 1)'(8);
	assign push_sh  = CNT_W'(BUFFER_BITS - 8) - cnt_q;
	assign push_vec = BUFFER_BITS'(byte_q) << push_sh;
	assign vs_sat   = (w_vs_q == 8'd255) ? w_vs_q : w_vs_q + 8'd1;
	assign rd_entry = rvld_q ? rd_q : bad_pkg::CTX_RESET;
	assign adapt1   = bad_pkg::ctx_adapt(c1_q, bin_q);
	assign mi1      = bad_pkg::ctx_mod(in_data[18:11], 11'(NUM_CONTEXTS));
	assign mi2      = bad_pkg::ctx_mod(in_data[26:19], 11'(NUM_CONTEXTS));

	// probability and predicted bin of the decode
	always_comb begin
		psum  = {1'b0, c1_q.prob} + {1'b0, c2_q.prob};
		pdiff = (c1_q.prob < c2_q.prob) ? c2_q.prob - c1_q.prob : c1_q.prob - c2_q.prob;
		pred  = 1'b0;
		lg    = 10'd1023;
		unique case (cmd_q)
			bad_pkg::CMD_REG: begin
				pred = c1_q.mps;
				lg   = c1_q.prob;
			end
			bad_pkg::CMD_WGT: begin
				if (c1_q.mps == c2_q.mps) begin
					pred = c1_q.mps;
					lg   = psum[10:1];
				end else begin
					pred = (c1_q.prob < c2_q.prob) ? c1_q.mps : c2_q.mps;
					lg   = 10'd1023 - {1'b0, pdiff[9:1]};
				end
			end
			bad_pkg::CMD_STF: lg = 10'd4;
			default: lg = 10'd1023;
		endcase
	end

	// interval split
	always_comb begin
		x        = lg[9:2];
		wrap     = w_rt_q < x;
		rs_inc   = {1'b0, w_rs_q} + {8'd0, wrap};
		rs2      = rs_inc[8] ? 8'd255 : rs_inc[7:0];
		rt2      = wrap ? 9'd256 + {1'b0, w_rt_q} - {1'b0, x} : {1'b0, w_rt_q - x};
		mps_path = !((rs2 > w_vs_q) || ((rs2 == w_vs_q) && (w_vt_q >= {7'd0, rt2})));
		vt_sub   = 17'd256 + {1'b0, vt_shift} - {8'd0, rt2};
	end

	always_comb begin
		rd_addr = (ctl.op == bad_pkg::OP_LAT1) ? idx2_q : idx1_q;
		mem_we  = (ctl.op == bad_pkg::OP_ADAPT1) || (ctl.op == bad_pkg::OP_ADAPT2);
		wr_addr = (ctl.op == bad_pkg::OP_ADAPT2) ? idx2_q : idx1_q;
		wr_data = (ctl.op == bad_pkg::OP_ADAPT2) ? bad_pkg::ctx_adapt(c2_q, bin_q) : adapt1;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[rd_addr];
			if (ctl.op == bad_pkg::OP_CLEAR) begin
				vld_q <= '0;
			end else if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			bad_pkg::OP_CAPTURE: begin
				cmd_q  <= bad_pkg::cmd_t'(in_data[2:0]);
				byte_q <= in_data[10:3];
				idx1_q <= CIDX_W'(mi1);
				idx2_q <= CIDX_W'(mi2);
				bin_q  <= 1'b0;
				stat_q <= bad_pkg::ST_OK;
			end
			bad_pkg::OP_START_INIT: begin
				w_rs_q  <= 8'd0;
				w_rt_q  <= 8'd255;
				w_vs_q  <= 8'd0;
				w_vt_q  <= 16'd0;
				taken_q <= '0;
				i_q     <= 4'd0;
			end
			bad_pkg::OP_LOAD: begin
				w_rs_q  <= rs_q;
				w_rt_q  <= rt_q;
				w_vs_q  <= vs_q;
				w_vt_q  <= {7'd0, vf_q};
				taken_q <= '0;
			end
			bad_pkg::OP_LAT1: begin
				c1_q <= rd_entry;
				c2_q <= rd_entry;
			end
			bad_pkg::OP_LAT2: c2_q <= rd_entry;
			bad_pkg::OP_SPLIT: begin
				i_q <= 4'd0;
				if (mps_path) begin
					bin_q  <= pred;
					w_rs_q <= rs2;
					w_rt_q <= rt2[7:0];
				end else begin
					bin_q <= ~pred;
					lr_q  <= wrap ? {1'b0, {1'b0, w_rt_q} + {1'b0, x}} : {2'd0, x};
					if (rs2 == w_vs_q) begin
						w_vt_q <= w_vt_q - {7'd0, rt2};
					end else begin
						w_vt_q  <= vt_sub[15:0];
						taken_q <= taken_q + CNT_W'(1);
					end
				end
			end
			bad_pkg::OP_SHIFT_START: begin
				w_vt_q  <= vt_shift;
				taken_q <= taken_q + CNT_W'(1);
				i_q     <= i_q + 4'd1;
			end
			bad_pkg::OP_SHIFT_NORM: begin
				w_vt_q  <= vt_shift;
				taken_q <= taken_q + CNT_W'(1);
				w_vs_q  <= vs_sat;
			end
			bad_pkg::OP_RENORM_STEP: begin
				lr_q    <= {lr_q[8:0], 1'b0};
				w_vt_q  <= vt_shift;
				taken_q <= taken_q + CNT_W'(1);
				i_q     <= i_q + 4'd1;
			end
			bad_pkg::OP_RENORM_END: begin
				w_rs_q <= 8'd0;
				w_rt_q <= lr_q[7:0];
				w_vs_q <= 8'd0;
			end
			bad_pkg::OP_ADAPT1: begin
				if (idx1_q == idx2_q) begin
					c2_q <= adapt1;
				end
			end
			bad_pkg::OP_SET_STATUS: begin
				stat_q <= ctl.status;
				bin_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// decoder state kept between commands; bit count and consumed bits appear in results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q     <= '0;
			cnt_q     <= '0;
			rs_q      <= 8'd0;
			rt_q      <= 8'd255;
			vs_q      <= 8'd0;
			vf_q      <= 9'd0;
			cons_q    <= 32'd0;
			started_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				bad_pkg::OP_PUSH: begin
					buf_q <= buf_q | push_vec;
					cnt_q <= cnt_q + CNT_W'(8);
				end
				bad_pkg::OP_COMMIT, bad_pkg::OP_COMMIT_START: begin
					rs_q   <= w_rs_q;
					rt_q   <= w_rt_q;
					vs_q   <= w_vs_q;
					vf_q   <= {1'b0, w_vt_q[7:0]};
					buf_q  <= buf_q << taken_q;
					cnt_q  <= cnt_q - taken_q;
					if (ctl.op == bad_pkg::OP_COMMIT_START) begin
						cons_q    <= 32'(taken_q);
						started_q <= 1'b1;
					end else begin
						cons_q <= cons_q + 32'(taken_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_data_q <= {6'd0, cons_q, 7'(cnt_q), stat_q, bin_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign st.cmd        = cmd_q;
	assign st.started    = started_q;
	assign st.have_bit   = taken_q < cnt_q;
	assign st.vt_low     = w_vt_q < 16'd256;
	assign st.i9         = i_q == 4'd9;
	assign st.lr_low     = lr_q < 10'd256;
	assign st.split_mps  = mps_path;
	assign st.split_same = rs2 == w_vs_q;
	assign st.full       = cnt_ext > (CNT_W + 1)'(BUFFER_BITS);
	assign st.out_free   = !out_valid_q || out_ready;

	`BAD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(BUFFER_BITS), "bit count above buffer size")
	`BAD_ASSERT_IMP(a_push_room, ctl.op == bad_pkg::OP_PUSH, !st.full, "push into a full buffer")
	`BAD_ASSERT_IMP(a_take_bound, ctl.op == bad_pkg::OP_COMMIT, taken_q <= cnt_q, "consumed more bits than held")
	`BAD_ASSERT_NEXT(a_start_sets, ctl.op == bad_pkg::OP_COMMIT_START, started_q, "start did not mark decoder started")

endmodule

[rtl/binary_arithmetic_bin_decoder.sv]
// channel    dir  width  fields
// s_axis     in   32     command, data_byte, context_index, second_context_index
// m_axis     out  48     bin_out, status, buffered_bits, bits_consumed
//
// one command at a time
// a decode or a start shifts value bits in one bit per cycle during normalization,
// and a decode reads its contexts one at a time through the single read port of the context memory
// reset clears the buffer, interval state and all context valid bits at once
// a new command is taken while the previous result waits in the output register
// depends on bad_pkg, bad_ctl, bad_dp
`timescale 1ns / 1ps

module binary_arithmetic_bin_decoder #(
	parameter int NUM_CONTEXTS = bad_pkg::NUM_CONTEXTS_DEF,
	parameter int BUFFER_BITS  = bad_pkg::BUFFER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // command, data_byte, context_index, second_context_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // bin_out, status, buffered_bits, bits_consumed
);

	bad_pkg::ctl_t     ctl;
	bad_pkg::dp_stat_t st;

	bad_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.ctl      (ctl)
	);

	bad_dp #(
		.NUM_CONTEXTS (NUM_CONTEXTS),
		.BUFFER_BITS  (BUFFER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.ctl       (ctl),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
